>>> design/mvp_pkg.sv
// Shared types, constants and helpers for the matrix-vector product block.
package mvp_pkg;

	localparam int MAX_DIM    = 64;
	localparam int ELEM_WIDTH = 16;

	localparam int IDX_W  = 6;
	localparam int VAL_W  = 16;
	localparam int DIM_W  = 7;
	localparam int ROW_W  = 6;
	localparam int ACC_W  = 38;
	localparam int AW     = $clog2(MAX_DIM);
	localparam int PROD_W = 2 * ELEM_WIDTH;

	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);
	localparam int QCW    = $clog2(QDEPTH + 1);

	typedef enum logic {
		OP_LOAD = 1'b0,
		OP_MAC  = 1'b1
	} op_t;

	typedef struct packed {
		logic signed [ELEM_WIDTH-1:0] elem;
		logic signed [ELEM_WIDTH-1:0] vec;
		logic                         row_end;
		logic [ROW_W-1:0]             row;
		logic                         last;
	} mac_word_t;

	function automatic logic [DIM_W-1:0] eff_n(input logic [DIM_W-1:0] n);
		logic [DIM_W-1:0] r;
		r = n;
		if (n == '0) begin
			r = DIM_W'(1);
		end else if (int'(n) > MAX_DIM) begin
			r = DIM_W'(MAX_DIM);
		end
		return r;
	endfunction

endpackage

>>> design/mvp_if.sv
// Valid/ready channel interfaces for input items and result words.
interface mvp_item_if import mvp_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             op;
	logic [IDX_W-1:0] elem_index;
	logic [VAL_W-1:0] elem_value;

	modport source (output valid, output op, output elem_index, output elem_value,
		input ready);
	modport sink (input valid, input op, input elem_index, input elem_value,
		output ready);
endinterface

interface mvp_result_if import mvp_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [ROW_W-1:0] row_index;
	logic [ACC_W-1:0] dot_value;
	logic             last_row;

	modport source (output valid, output row_index, output dot_value, output last_row,
		input ready);
	modport sink (input valid, input row_index, input dot_value, input last_row,
		output ready);
endinterface

>>> design/mvp_front.sv
// Front end: takes items, holds the vector store, tracks row and column position.
module mvp_front import mvp_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [DIM_W-1:0] cfg_wdata,
	mvp_item_if.sink         items,
	output mac_word_t        push_word,
	output logic             push_valid,
	input  logic             push_ready
);

	logic [ELEM_WIDTH-1:0] vstore [MAX_DIM];
	logic [ELEM_WIDTH-1:0] rd_q;

	logic [DIM_W-1:0] n_q;
	logic [DIM_W-1:0] neff;
	logic [IDX_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [DIM_W-1:0] col_inc;
	logic [DIM_W-1:0] row_inc;
	logic             row_end;
	logic             prod_end;
	logic             accept;
	logic             is_mac;

	logic                         valid_s1;
	logic signed [ELEM_WIDTH-1:0] elem_s1;
	logic                         col_ok_s1;
	logic                         row_end_s1;
	logic [ROW_W-1:0]             row_s1;
	logic                         last_s1;

	assign neff     = eff_n(n_q);
	assign col_inc  = DIM_W'(col_q) + DIM_W'(1);
	assign row_inc  = DIM_W'(row_q) + DIM_W'(1);
	assign row_end  = col_inc >= neff;
	assign prod_end = row_inc >= neff;

	assign items.ready = !valid_s1 || push_ready;
	assign accept      = items.valid && items.ready;
	assign is_mac      = op_t'(items.op) == OP_MAC;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q <= DIM_W'(MAX_DIM);
		end else if (cfg_we) begin
			n_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !is_mac && (int'(items.elem_index) < MAX_DIM)) begin
			vstore[items.elem_index[AW-1:0]] <= items.elem_value[ELEM_WIDTH-1:0];
		end
		if (accept && is_mac) begin
			rd_q <= vstore[col_q[AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (items.ready) begin
				valid_s1 <= accept && is_mac;
			end
			if (accept && is_mac) begin
				if (row_end) begin
					col_q <= '0;
					row_q <= prod_end ? '0 : row_inc[ROW_W-1:0];
				end else begin
					col_q <= col_inc[IDX_W-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && is_mac) begin
			elem_s1    <= items.elem_value[ELEM_WIDTH-1:0];
			col_ok_s1  <= int'(col_q) < MAX_DIM;
			row_end_s1 <= row_end;
			row_s1     <= row_q;
			last_s1    <= prod_end;
		end
	end

	assign push_valid        = valid_s1;
	assign push_word.elem    = elem_s1;
	assign push_word.vec     = col_ok_s1 ? rd_q : '0;
	assign push_word.row_end = row_end_s1;
	assign push_word.row     = row_s1;
	assign push_word.last    = last_s1;

`ifndef NO_ASSERTIONS
	a_load_no_push: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !is_mac) |=> !valid_s1)
		else $error("vector load produced a queue word");
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !push_ready) |=> (valid_s1 && $stable(row_s1) && $stable(row_end_s1)))
		else $error("stalled front word changed");
`endif

endmodule

>>> design/mvp_queue.sv
// Short queue of multiply-accumulate words between front and back.
module mvp_queue import mvp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  mac_word_t push_word,
	input  logic      push_valid,
	output logic      push_ready,
	output mac_word_t pop_word,
	output logic      pop_valid,
	input  logic      pop_ready
);

	mac_word_t        entry_q [QDEPTH];
	logic [QAW-1:0]   wptr_q;
	logic [QAW-1:0]   rptr_q;
	logic [QCW-1:0]   count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = count_q != QCW'(QDEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_word   = entry_q[rptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wptr_q] <= push_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= wptr_q + QAW'(1);
			end
			if (do_pop) begin
				rptr_q <= rptr_q + QAW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + QCW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - QCW'(1);
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		int'(count_q) <= QDEPTH)
		else $error("queue count beyond depth");
`endif

endmodule

>>> design/mvp_back.sv
// Back end: multiply, accumulate per row, and registered result word.
module mvp_back import mvp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  mac_word_t pop_word,
	input  logic      pop_valid,
	output logic      pop_ready,
	mvp_result_if.source results
);

	logic                     adv;
	logic                     valid_s1;
	logic signed [PROD_W-1:0] prod_s1;
	logic                     row_end_s1;
	logic [ROW_W-1:0]         row_s1;
	logic                     last_s1;
	logic [ACC_W-1:0]         acc_q;
	logic [ACC_W-1:0]         acc_sum;
	logic                     res_valid_q;
	logic [ROW_W-1:0]         res_row_q;
	logic [ACC_W-1:0]         res_dot_q;
	logic                     res_last_q;

	assign adv       = !res_valid_q || results.ready;
	assign pop_ready = adv;
	assign acc_sum   = acc_q + {{(ACC_W-PROD_W){prod_s1[PROD_W-1]}}, prod_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			acc_q       <= '0;
			res_valid_q <= 1'b0;
		end else if (adv) begin
			valid_s1    <= pop_valid;
			res_valid_q <= valid_s1 && row_end_s1;
			if (valid_s1) begin
				acc_q <= row_end_s1 ? '0 : acc_sum;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && pop_valid) begin
			prod_s1    <= pop_word.elem * pop_word.vec;
			row_end_s1 <= pop_word.row_end;
			row_s1     <= pop_word.row;
			last_s1    <= pop_word.last;
		end
		if (adv && valid_s1 && row_end_s1) begin
			res_row_q  <= row_s1;
			res_dot_q  <= acc_sum;
			res_last_q <= last_s1;
		end
	end

	assign results.valid     = res_valid_q;
	assign results.row_index = res_row_q;
	assign results.dot_value = res_dot_q;
	assign results.last_row  = res_last_q;

`ifndef NO_ASSERTIONS
	a_acc_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && valid_s1 && row_end_s1) |=> (acc_q == '0))
		else $error("sum not cleared after row end");
	a_acc_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!(adv && valid_s1) |=> $stable(acc_q))
		else $error("sum changed without a word");
`endif

endmodule

>>> design/matrix_vector_product.sv
// Dense matrix-vector product: vector words load the local store by index, matrix words
// stream in row-major order and one row dot product leaves per row; the block takes one
// word per cycle while results are taken, set by the single multiply-accumulate in the back
// end, and a result word is valid once the last matrix word of its row has passed the
// store read, the queue and the multiply and been accumulated into the result register,
// with a four-entry queue between the store front end and the multiplier.
module matrix_vector_product import mvp_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [DIM_W-1:0] cfg_wdata,
	mvp_item_if.sink         items,
	mvp_result_if.source     results
);

	mac_word_t push_word;
	logic      push_valid;
	logic      push_ready;
	mac_word_t pop_word;
	logic      pop_valid;
	logic      pop_ready;

	mvp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.items      (items),
		.push_word  (push_word),
		.push_valid (push_valid),
		.push_ready (push_ready)
	);

	mvp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_word  (push_word),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.pop_word   (pop_word),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready)
	);

	mvp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_word  (pop_word),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.results   (results)
	);

endmodule

>>> tb/tb_matrix_vector_product.sv
// Self-checking testbench for the matrix-vector product block against a local predictor.
module tb_matrix_vector_product;
	import mvp_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 20;
	localparam int IDLE_PCT = 14;
	localparam int HOLD_CYCLES = 80;
	localparam int RANDOM_WORDS = 1500;
	localparam int REPORT_MAX = 10;

	typedef struct packed {
		logic [ROW_W-1:0] row;
		logic [ACC_W-1:0] dot;
		logic             last;
	} row_result_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_we = 1'b0;
	logic [DIM_W-1:0] cfg_wdata = '0;

	mvp_item_if   item_bus ();
	mvp_result_if res_bus ();

	matrix_vector_product u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.items    (item_bus.sink),
		.results  (res_bus.source)
	);

	always #5 clk = ~clk;

	// predictor state
	logic [DIM_W-1:0] n_cfg = DIM_W'(MAX_DIM);
	logic [VAL_W-1:0] vec_mem [MAX_DIM];
	logic [ACC_W-1:0] dot_acc = '0;
	logic [IDX_W-1:0] col_cnt = '0;
	logic [ROW_W-1:0] row_cnt = '0;
	row_result_t      row_q [$];

	int          errors = 0;
	int          tx_idle_pct = IDLE_PCT;
	int          rx_idle_pct = IDLE_PCT;
	bit          hold_pending = 1'b0;
	int          hold_left = 0;
	int unsigned cycle_cnt = 0;

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
	end

	initial begin
		wait (cycle_cnt >= CYCLE_LIMIT);
		$display("Verification failed");
		$finish;
	end

	function automatic int active_dim();
		if (n_cfg == '0) begin
			return 1;
		end
		if (int'(n_cfg) > MAX_DIM) begin
			return MAX_DIM;
		end
		return int'(n_cfg);
	endfunction

	task automatic predict_word(input op_t op, input logic [IDX_W-1:0] idx,
		input logic [VAL_W-1:0] val);
		int          n;
		longint      prod;
		row_result_t r;
		n = active_dim();
		if (op == OP_LOAD) begin
			vec_mem[idx] = val;
			return;
		end
		prod = longint'($signed(val)) * longint'($signed(vec_mem[col_cnt]));
		dot_acc = dot_acc + ACC_W'(prod);
		if (int'(col_cnt) + 1 < n) begin
			col_cnt = col_cnt + 1'b1;
			return;
		end
		r.row = row_cnt;
		r.dot = dot_acc;
		r.last = (int'(row_cnt) + 1 >= n);
		row_q.push_back(r);
		dot_acc = '0;
		col_cnt = '0;
		row_cnt = r.last ? '0 : row_cnt + 1'b1;
	endtask

	function automatic logic [VAL_W-1:0] rand_elem();
		case ($urandom_range(15))
			0: begin
				return 16'h8000;
			end
			1: begin
				return 16'h7FFF;
			end
			2: begin
				return 16'h0000;
			end
			3: begin
				return 16'hFFFF;
			end
			default: begin
				return VAL_W'($urandom);
			end
		endcase
	endfunction

	// entered and left just after a falling edge
	task automatic send_word(input op_t op, input logic [IDX_W-1:0] idx,
		input logic [VAL_W-1:0] val);
		while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
			item_bus.valid <= 1'b0;
			@(negedge clk);
		end
		item_bus.valid <= 1'b1;
		item_bus.op <= op;
		item_bus.elem_index <= idx;
		item_bus.elem_value <= val;
		@(posedge clk);
		while (!item_bus.ready) begin
			@(posedge clk);
		end
		predict_word(op, idx, val);
		@(negedge clk);
	endtask

	task automatic send_mac(input logic [VAL_W-1:0] val);
		send_word(OP_MAC, IDX_W'($urandom), val);
	endtask

	task automatic drain();
		item_bus.valid <= 1'b0;
		while (row_q.size() != 0) begin
			@(negedge clk);
		end
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic set_size(input logic [DIM_W-1:0] n);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= n;
		@(negedge clk);
		cfg_we <= 1'b0;
		n_cfg = n;
	endtask

	// reset size is MAX_DIM; full-scale rows, then a size cut in the middle of a row
	task automatic test_reset_size();
		for (int i = 0; i < MAX_DIM; i++) begin
			send_word(OP_LOAD, IDX_W'(i), 16'h8000);
		end
		repeat (MAX_DIM) send_mac(16'h8000);
		repeat (MAX_DIM) send_mac(16'h7FFF);
		repeat (10) send_mac(rand_elem());
		set_size(DIM_W'(3));
		send_mac(rand_elem());
		repeat (3) send_mac(rand_elem());
	endtask

	task automatic test_vector_load();
		for (int i = 0; i < MAX_DIM; i++) begin
			send_word(OP_LOAD, IDX_W'(i), rand_elem());
		end
	endtask

	task automatic test_extremes();
		set_size(DIM_W'(2));
		send_word(OP_LOAD, IDX_W'(0), 16'h7FFF);
		send_word(OP_LOAD, IDX_W'(1), 16'h8000);
		send_mac(16'h8000);
		send_mac(16'h7FFF);
		send_mac(16'h7FFF);
		send_mac(16'h8000);
		send_mac(16'h0000);
		send_mac(16'hFFFF);
		// vector reload in the middle of a row
		send_mac(16'h1234);
		send_word(OP_LOAD, IDX_W'(1), 16'hFFFF);
		send_mac(16'h8000);
		send_word(OP_LOAD, IDX_W'(MAX_DIM - 1), 16'h5A5A);
		send_word(OP_LOAD, IDX_W'(42), 16'hA5A5);
	endtask

	task automatic test_size_clamp();
		set_size(DIM_W'(0));
		repeat (3) send_mac(rand_elem());
		set_size(DIM_W'(127));
		repeat (MAX_DIM) send_mac(rand_elem());
		set_size(DIM_W'(1));
		repeat (2) send_mac(rand_elem());
		set_size(DIM_W'(8));
		repeat (5) send_mac(rand_elem());
		set_size(DIM_W'(3));
		send_mac(rand_elem());
		set_size(DIM_W'(MAX_DIM));
		repeat (MAX_DIM) send_mac(rand_elem());
	endtask

	task automatic test_backpressure();
		set_size(DIM_W'(1));
		tx_idle_pct = 0;
		hold_pending = 1'b1;
		repeat (60) send_mac(rand_elem());
		tx_idle_pct = IDLE_PCT;
	endtask

	task automatic test_random();
		int               sent;
		int               len;
		int               pick;
		logic [DIM_W-1:0] n;
		sent = 0;
		while (sent < RANDOM_WORDS) begin
			pick = $urandom_range(99);
			if (pick < 70) begin
				n = DIM_W'($urandom_range(8, 1));
			end else if (pick < 90) begin
				n = DIM_W'($urandom_range(20, 9));
			end else if (pick < 95) begin
				n = '0;
			end else begin
				n = DIM_W'($urandom_range(127, MAX_DIM + 1));
			end
			set_size(n);
			if (sent >= 800 && sent < 1100) begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end else begin
				tx_idle_pct = IDLE_PCT;
				rx_idle_pct = IDLE_PCT;
			end
			len = $urandom_range(120, 30);
			for (int i = 0; i < len; i++) begin
				if ($urandom_range(99) < 15) begin
					send_word(OP_LOAD, IDX_W'($urandom), rand_elem());
				end else begin
					send_mac(rand_elem());
				end
			end
			sent += len;
		end
		tx_idle_pct = IDLE_PCT;
		rx_idle_pct = IDLE_PCT;
	endtask

	initial begin
		item_bus.valid = 1'b0;
		item_bus.op = OP_LOAD;
		item_bus.elem_index = '0;
		item_bus.elem_value = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_reset_size();
		test_vector_load();
		test_extremes();
		test_size_clamp();
		test_backpressure();
		test_random();
		drain();
		if (errors == 0 && row_q.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

	// result side: random stalls plus one long hold on request
	initial begin
		res_bus.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_pending) begin
				hold_pending = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_bus.ready <= 1'b0;
			end else begin
				res_bus.ready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	always @(posedge clk) begin : check_rows
		row_result_t want;
		if (arst_n && res_bus.valid && res_bus.ready) begin
			if (row_q.size() == 0) begin
				errors++;
				if (errors <= REPORT_MAX) begin
					$display("unexpected word: row %0d dot %0d last %0b", res_bus.row_index,
						$signed(res_bus.dot_value), res_bus.last_row);
				end
			end else begin
				want = row_q.pop_front();
				if (res_bus.row_index !== want.row || res_bus.dot_value !== want.dot
					|| res_bus.last_row !== want.last) begin
					errors++;
					if (errors <= REPORT_MAX) begin
						$display("mismatch: expected row %0d dot %0d last %0b",
							want.row, $signed(want.dot), want.last);
						$display("          got row %0d dot %0d last %0b",
							res_bus.row_index, $signed(res_bus.dot_value),
							res_bus.last_row);
					end
				end
			end
		end
	end

endmodule
